>>> rtl/core/ffpc_pkg.sv
// shared types, command codes and gain coefficient table of the peak compressor
package ffpc_pkg;

   localparam int SAMPLE_W = 24;
   localparam int FRAC_W   = 16;
   localparam int MANT_W   = 31;
   localparam int OPND_W   = 32;
   localparam int PROD_W   = 64;
   localparam int CMD_W    = 5;
   localparam int STEP_W   = 4;
   localparam int STEPS    = 16;

   localparam logic [CMD_W-1:0] CMD_NONE      = 5'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD      = 5'd1;
   localparam logic [CMD_W-1:0] CMD_ENV_A     = 5'd2;
   localparam logic [CMD_W-1:0] CMD_ENV_B     = 5'd3;
   localparam logic [CMD_W-1:0] CMD_ENV_WR    = 5'd4;
   localparam logic [CMD_W-1:0] CMD_LOG_START = 5'd5;
   localparam logic [CMD_W-1:0] CMD_LOG_STEP  = 5'd6;
   localparam logic [CMD_W-1:0] CMD_LOG_SAVE  = 5'd7;
   localparam logic [CMD_W-1:0] CMD_N_MUL     = 5'd8;
   localparam logic [CMD_W-1:0] CMD_N_SAVE    = 5'd9;
   localparam logic [CMD_W-1:0] CMD_EXP_STEP  = 5'd10;
   localparam logic [CMD_W-1:0] CMD_GAIN      = 5'd11;
   localparam logic [CMD_W-1:0] CMD_UNITY     = 5'd12;
   localparam logic [CMD_W-1:0] CMD_WET1      = 5'd13;
   localparam logic [CMD_W-1:0] CMD_WET2      = 5'd14;
   localparam logic [CMD_W-1:0] CMD_MIX1      = 5'd15;
   localparam logic [CMD_W-1:0] CMD_MIX2      = 5'd16;
   localparam logic [CMD_W-1:0] CMD_OUT1      = 5'd17;
   localparam logic [CMD_W-1:0] CMD_RESULT    = 5'd18;
   localparam logic [CMD_W-1:0] CMD_BYPASS    = 5'd19;

   typedef struct packed {
      logic [CMD_W-1:0]  op;
      logic              log_thr;
      logic [STEP_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic compress;
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic [23:0] thr;
      logic [16:0] slope;
      logic [23:0] att;
      logic [23:0] rel;
      logic [20:0] makeup;
      logic [16:0] wet;
      logic [18:0] og;
      logic        byp;
   } cfg_type;

   typedef logic [MANT_W-1:0] coef_tab_type [STEPS];

   // c(i) = floor(sqrt(c(i-1) * 2^30)), starting from one half
   function automatic coef_tab_type make_coef_table();
      coef_tab_type t;
      logic [63:0]  c;
      logic [63:0]  v;
      logic [63:0]  r;
      logic [63:0]  b;
      c = 64'd1 << 29;
      for (int i = 0; i < STEPS; i++) begin
         v = c << 30;
         r = 64'd0;
         b = 64'd1 << 62;
         for (int j = 0; j < 32; j++) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         c = r;
         t[i] = c[MANT_W-1:0];
      end
      return t;
   endfunction

   localparam coef_tab_type EXP_COEF = make_coef_table();

endpackage

>>> rtl/core/ffpc_req_if.sv
// input channel: sample and channel tag with valid/ready
interface ffpc_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample_in;
   logic               channel;
   modport source (output valid, sample_in, channel, input ready);
   modport sink (input valid, sample_in, channel, output ready);
endinterface

>>> rtl/core/ffpc_rsp_if.sv
// result channel: processed sample and channel tag with valid/ready
interface ffpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample_out;
   logic               channel_out;
   modport source (output valid, sample_out, channel_out, input ready);
   modport sink (input valid, sample_out, channel_out, output ready);
endinterface

>>> rtl/core/feedforward_peak_compressor.sv
// top level: register file, sequencer and datapath of the peak compressor
//
//   port     dir    handshake          beat
//   req_bus  sink   valid/ready        sample_in, channel
//   rsp_bus  source valid/ready        sample_out, channel_out
//   csr_*    in     csr_we, no stall   csr_index, csr_wdata
//
// a sample goes from acceptance through the envelope update and unity gain to the output
// register with no gain reduction; when the envelope is above threshold, two log2 squaring
// loops and an exp2 product loop replace unity gain, all on the one 32x32 multiplier;
// one sample in flight; the output register holds a finished beat while the next is accepted
// a stalled rsp_bus holds the sequencer in its last step; synchronous reset clears envelopes
module feedforward_peak_compressor #(
   parameter int CHANNELS = 2
) (
   input  logic        clock,
   input  logic        reset,
   ffpc_req_if.sink    req_bus,
   ffpc_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam logic [2:0] CSR_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_SLOPE     = 3'd1;
   localparam logic [2:0] CSR_ATTACK    = 3'd2;
   localparam logic [2:0] CSR_RELEASE   = 3'd3;
   localparam logic [2:0] CSR_MAKEUP    = 3'd4;
   localparam logic [2:0] CSR_WET       = 3'd5;
   localparam logic [2:0] CSR_OUT_GAIN  = 3'd6;
   localparam logic [2:0] CSR_BYPASS    = 3'd7;

   ffpc_pkg::cfg_type  cfg_ff, cfg_in;
   ffpc_pkg::cmd_type  cmd;
   ffpc_pkg::stat_type stat;
   logic [23:0]        out_sample;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: cfg_in.thr    = csr_wdata;
            CSR_SLOPE:     cfg_in.slope  = csr_wdata[16:0];
            CSR_ATTACK:    cfg_in.att    = csr_wdata;
            CSR_RELEASE:   cfg_in.rel    = csr_wdata;
            CSR_MAKEUP:    cfg_in.makeup = csr_wdata[20:0];
            CSR_WET:       cfg_in.wet    = csr_wdata[16:0];
            CSR_OUT_GAIN:  cfg_in.og     = csr_wdata[18:0];
            CSR_BYPASS:    cfg_in.byp    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr    <= 24'd1056069;
         cfg_ff.slope  <= 17'h14000;
         cfg_ff.att    <= 24'd16748107;
         cfg_ff.rel    <= 24'd16775032;
         cfg_ff.makeup <= 21'd103870;
         cfg_ff.wet    <= 17'd65536;
         cfg_ff.og     <= 19'd65536;
         cfg_ff.byp    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ffpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .byp       (cfg_ff.byp),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_bus.ready)
   );

   ffpc_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg_ff),
      .in_sample   (req_bus.sample_in),
      .in_channel  (req_bus.channel),
      .out_ready   (rsp_bus.ready),
      .stat        (stat),
      .out_valid   (rsp_bus.valid),
      .out_sample  (out_sample),
      .out_channel (rsp_bus.channel_out)
   );

   assign rsp_bus.sample_out = out_sample;

endmodule

>>> rtl/core/ffpc_ctrl.sv
// sequencer issuing one datapath command per cycle, holding its last step while the output register is not free
module ffpc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               byp,
   input  ffpc_pkg::stat_type stat,
   output ffpc_pkg::cmd_type  cmd,
   output logic               req_ready
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_ENV_A  = 5'd1;
   localparam logic [4:0] S_ENV_B  = 5'd2;
   localparam logic [4:0] S_ENV_WR = 5'd3;
   localparam logic [4:0] S_LOG_E  = 5'd4;
   localparam logic [4:0] S_LOG_T  = 5'd5;
   localparam logic [4:0] S_N_MUL  = 5'd6;
   localparam logic [4:0] S_N_SAVE = 5'd7;
   localparam logic [4:0] S_EXP    = 5'd8;
   localparam logic [4:0] S_GAIN   = 5'd9;
   localparam logic [4:0] S_UNITY  = 5'd10;
   localparam logic [4:0] S_WET1   = 5'd11;
   localparam logic [4:0] S_WET2   = 5'd12;
   localparam logic [4:0] S_MIX1   = 5'd13;
   localparam logic [4:0] S_MIX2   = 5'd14;
   localparam logic [4:0] S_OUT1   = 5'd15;
   localparam logic [4:0] S_RESULT = 5'd16;
   localparam logic [4:0] S_BYPASS = 5'd17;

   localparam logic [4:0] LOG_LAST = 5'(ffpc_pkg::STEPS);
   localparam logic [4:0] EXP_LAST = 5'(ffpc_pkg::STEPS - 1);

   logic [4:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd.op      = ffpc_pkg::CMD_NONE;
      cmd.log_thr = 1'b0;
      cmd.idx     = cnt_ff[ffpc_pkg::STEP_W-1:0];
      unique case (state_ff) inside
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ffpc_pkg::CMD_LOAD;
               state_in = byp ? S_BYPASS : S_ENV_A;
            end
         end
         S_ENV_A: begin
            cmd.op   = ffpc_pkg::CMD_ENV_A;
            state_in = S_ENV_B;
         end
         S_ENV_B: begin
            cmd.op   = ffpc_pkg::CMD_ENV_B;
            state_in = S_ENV_WR;
         end
         S_ENV_WR: begin
            cmd.op   = ffpc_pkg::CMD_ENV_WR;
            cnt_in   = 5'd0;
            state_in = stat.compress ? S_LOG_E : S_UNITY;
         end
         S_LOG_E, S_LOG_T: begin
            cmd.log_thr = (state_ff == S_LOG_T);
            if (cnt_ff == 5'd0) begin
               cmd.op = ffpc_pkg::CMD_LOG_START;
            end else if (cnt_ff == LOG_LAST) begin
               cmd.op = ffpc_pkg::CMD_LOG_SAVE;
            end else begin
               cmd.op = ffpc_pkg::CMD_LOG_STEP;
            end
            if (cnt_ff == LOG_LAST) begin
               cnt_in   = 5'd0;
               state_in = (state_ff == S_LOG_T) ? S_N_MUL : S_LOG_T;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_N_MUL: begin
            cmd.op   = ffpc_pkg::CMD_N_MUL;
            state_in = S_N_SAVE;
         end
         S_N_SAVE: begin
            cmd.op   = ffpc_pkg::CMD_N_SAVE;
            cnt_in   = 5'd0;
            state_in = S_EXP;
         end
         S_EXP: begin
            cmd.op = ffpc_pkg::CMD_EXP_STEP;
            if (cnt_ff == EXP_LAST) begin
               state_in = S_GAIN;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_GAIN: begin
            cmd.op   = ffpc_pkg::CMD_GAIN;
            state_in = S_WET1;
         end
         S_UNITY: begin
            cmd.op   = ffpc_pkg::CMD_UNITY;
            state_in = S_WET1;
         end
         S_WET1: begin
            cmd.op   = ffpc_pkg::CMD_WET1;
            state_in = S_WET2;
         end
         S_WET2: begin
            cmd.op   = ffpc_pkg::CMD_WET2;
            state_in = S_MIX1;
         end
         S_MIX1: begin
            cmd.op   = ffpc_pkg::CMD_MIX1;
            state_in = S_MIX2;
         end
         S_MIX2: begin
            cmd.op   = ffpc_pkg::CMD_MIX2;
            state_in = S_OUT1;
         end
         S_OUT1: begin
            cmd.op   = ffpc_pkg::CMD_OUT1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.op   = ffpc_pkg::CMD_RESULT;
               state_in = S_IDLE;
            end
         end
         S_BYPASS: begin
            if (stat.out_free) begin
               cmd.op   = ffpc_pkg::CMD_BYPASS;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/core/ffpc_dp.sv
// datapath: envelope store, shared multiplier, log/exp iteration and output register
module ffpc_dp #(
   parameter int CHANNELS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  ffpc_pkg::cmd_type  cmd,
   input  ffpc_pkg::cfg_type  cfg,
   input  logic [23:0]        in_sample,
   input  logic               in_channel,
   input  logic               out_ready,
   output ffpc_pkg::stat_type stat,
   output logic               out_valid,
   output logic [23:0]        out_sample,
   output logic               out_channel
);

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

   logic [23:0] env_ff [CHANNELS];
   logic [23:0] env_in [CHANNELS];
   logic        outv_ff, outv_in;

   logic [23:0] raw_ff, raw_in;
   logic [23:0] xm_ff, xm_in;
   logic        neg_ff, neg_in;
   logic        chb_ff, chb_in;
   logic [23:0] envn_ff, envn_in;
   logic [63:0] prod_ff, prod_in;
   logic [15:0] fr_ff, fr_in;
   logic [4:0]  lp_ff, lp_in;
   logic [20:0] le_ff, le_in;
   logic [31:0] d_ff, d_in;
   logic [15:0] nf_ff, nf_in;
   logic        kbig_ff, kbig_in;
   logic [4:0]  ksh_ff, ksh_in;
   logic [30:0] acc_ff, acc_in;
   logic        app_ff, app_in;
   logic [30:0] g_ff, g_in;
   logic [27:0] wet_ff, wet_in;
   logic [23:0] outs_ff, outs_in;
   logic        outc_ff, outc_in;

   logic [IW-1:0] idx;
   logic [23:0]   env_cur;
   logic [23:0]   coef;
   logic [24:0]   inv_coef;
   logic [23:0]   env_nx;
   logic [23:0]   lv;
   logic [4:0]    lp;
   logic [30:0]   m0;
   logic [32:0]   sq;
   logic          sbit;
   logic [30:0]   msq;
   logic [15:0]   frn;
   logic [20:0]   lnew;
   logic [30:0]   ecur;
   logic [30:0]   mfin;
   logic [16:0]   smag;
   logic [16:0]   w;
   logic [16:0]   inv_w;
   logic [31:0]   ymag;
   logic [23:0]   ysat;
   logic [23:0]   xabs;
   logic [31:0]   op_a;
   logic [31:0]   op_b;
   logic [63:0]   addend;
   logic          mul_en;
   logic [63:0]   mul_res;

   assign idx      = (CHANNELS > 1) ? IW'(chb_ff) : '0;
   assign env_cur  = env_ff[idx];
   assign coef     = (xm_ff > env_cur) ? cfg.att : cfg.rel;
   assign inv_coef = (25'd1 << 24) - {1'b0, coef};
   assign env_nx   = prod_ff[47:24];

   assign stat.compress = (env_nx > cfg.thr) && (env_nx != 24'd0) && cfg.slope[16];
   assign stat.out_free = !outv_ff || out_ready;

   // log2 front end: top set bit and normalized mantissa
   assign lv = cmd.log_thr ? ((cfg.thr == 24'd0) ? 24'd1 : cfg.thr) : envn_ff;

   always_comb begin
      lp = 5'd0;
      for (int b = 0; b < 24; b++) begin
         if (lv[b]) begin
            lp = 5'(b);
         end
      end
   end

   assign m0   = 31'({7'd0, lv} << (5'd30 - lp));
   assign sq   = prod_ff[62:30];
   assign sbit = sq[31];
   assign msq  = sbit ? sq[31:1] : sq[30:0];
   assign frn  = {fr_ff[14:0], sbit};
   assign lnew = {lp_ff, frn};

   assign ecur = (cmd.idx == '0) ? ONE_Q30 : (app_ff ? prod_ff[60:30] : acc_ff);
   assign mfin = app_ff ? prod_ff[60:30] : acc_ff;

   assign smag  = 17'd0 - cfg.slope;
   assign w     = (cfg.wet > 17'd65536) ? 17'd65536 : cfg.wet;
   assign inv_w = 17'd65536 - w;

   assign ymag = prod_ff[47:16];
   always_comb begin
      if (neg_ff) begin
         ysat = (ymag > 32'd8388608) ? 24'h800000 : 24'(24'd0 - ymag[23:0]);
      end else begin
         ysat = (ymag > 32'd8388607) ? 24'h7fffff : ymag[23:0];
      end
   end

   assign xabs = in_sample[23] ? 24'(24'd0 - in_sample) : in_sample;

   // shared multiplier operand selection
   always_comb begin
      op_a   = 32'd0;
      op_b   = 32'd0;
      addend = 64'd0;
      mul_en = 1'b1;
      case (cmd.op)
         ffpc_pkg::CMD_ENV_A: begin
            op_a   = 32'(xm_ff);
            op_b   = 32'(inv_coef);
            addend = 64'd1 << 23;
         end
         ffpc_pkg::CMD_ENV_B: begin
            op_a   = 32'(env_cur);
            op_b   = 32'(coef);
            addend = prod_ff;
         end
         ffpc_pkg::CMD_LOG_START: begin
            op_a = 32'(m0);
            op_b = 32'(m0);
         end
         ffpc_pkg::CMD_LOG_STEP: begin
            op_a = 32'(msq);
            op_b = 32'(msq);
         end
         ffpc_pkg::CMD_N_MUL: begin
            op_a   = 32'(smag);
            op_b   = d_ff;
            addend = 64'd1 << 15;
         end
         ffpc_pkg::CMD_EXP_STEP: begin
            op_a   = 32'(ecur);
            op_b   = 32'(ffpc_pkg::EXP_COEF[cmd.idx]);
            addend = 64'd1 << 29;
         end
         ffpc_pkg::CMD_WET1: begin
            op_a   = 32'(xm_ff);
            op_b   = 32'(g_ff);
            addend = 64'd1 << 29;
         end
         ffpc_pkg::CMD_WET2: begin
            op_a   = 32'(prod_ff[53:30]);
            op_b   = 32'(cfg.makeup);
            addend = 64'd1 << 15;
         end
         ffpc_pkg::CMD_MIX1: begin
            op_a   = 32'(xm_ff);
            op_b   = 32'(inv_w);
            addend = 64'd1 << 15;
         end
         ffpc_pkg::CMD_MIX2: begin
            op_a   = 32'(wet_ff);
            op_b   = 32'(w);
            addend = prod_ff;
         end
         ffpc_pkg::CMD_OUT1: begin
            op_a   = 32'(prod_ff[44:16]);
            op_b   = 32'(cfg.og);
            addend = 64'd1 << 15;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign mul_res = {32'd0, op_a} * {32'd0, op_b} + addend;

   always_comb begin
      env_in  = env_ff;
      outv_in = outv_ff && !out_ready;
      raw_in  = raw_ff;
      xm_in   = xm_ff;
      neg_in  = neg_ff;
      chb_in  = chb_ff;
      envn_in = envn_ff;
      prod_in = mul_en ? mul_res : prod_ff;
      fr_in   = fr_ff;
      lp_in   = lp_ff;
      le_in   = le_ff;
      d_in    = d_ff;
      nf_in   = nf_ff;
      kbig_in = kbig_ff;
      ksh_in  = ksh_ff;
      acc_in  = acc_ff;
      app_in  = app_ff;
      g_in    = g_ff;
      wet_in  = wet_ff;
      outs_in = outs_ff;
      outc_in = outc_ff;
      case (cmd.op)
         ffpc_pkg::CMD_LOAD: begin
            raw_in = in_sample;
            xm_in  = xabs;
            neg_in = in_sample[23];
            chb_in = in_channel;
         end
         ffpc_pkg::CMD_ENV_WR: begin
            env_in[idx] = env_nx;
            envn_in     = env_nx;
         end
         ffpc_pkg::CMD_LOG_START: begin
            lp_in = lp;
            fr_in = 16'd0;
         end
         ffpc_pkg::CMD_LOG_STEP: begin
            fr_in = frn;
         end
         ffpc_pkg::CMD_LOG_SAVE: begin
            if (cmd.log_thr) begin
               d_in = {11'd0, le_ff} - {11'd0, lnew};
            end else begin
               le_in = lnew;
            end
         end
         ffpc_pkg::CMD_N_SAVE: begin
            nf_in   = prod_ff[31:16];
            kbig_in = (prod_ff[48:32] >= 17'd31);
            ksh_in  = prod_ff[36:32];
         end
         ffpc_pkg::CMD_EXP_STEP: begin
            acc_in = ecur;
            app_in = nf_ff[4'd15 - cmd.idx];
         end
         ffpc_pkg::CMD_GAIN: begin
            g_in = kbig_ff ? 31'd0 : (mfin >> ksh_ff);
         end
         ffpc_pkg::CMD_UNITY: begin
            g_in = ONE_Q30;
         end
         ffpc_pkg::CMD_MIX1: begin
            wet_in = prod_ff[43:16];
         end
         ffpc_pkg::CMD_RESULT: begin
            outs_in = ysat;
            outc_in = chb_ff;
            outv_in = 1'b1;
         end
         ffpc_pkg::CMD_BYPASS: begin
            outs_in = raw_ff;
            outc_in = chb_ff;
            outv_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            env_ff[i] <= 24'd0;
         end
         outv_ff <= 1'b0;
      end else begin
         env_ff  <= env_in;
         outv_ff <= outv_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      xm_ff   <= xm_in;
      neg_ff  <= neg_in;
      chb_ff  <= chb_in;
      envn_ff <= envn_in;
      prod_ff <= prod_in;
      fr_ff   <= fr_in;
      lp_ff   <= lp_in;
      le_ff   <= le_in;
      d_ff    <= d_in;
      nf_ff   <= nf_in;
      kbig_ff <= kbig_in;
      ksh_ff  <= ksh_in;
      acc_ff  <= acc_in;
      app_ff  <= app_in;
      g_ff    <= g_in;
      wet_ff  <= wet_in;
      outs_ff <= outs_in;
      outc_ff <= outc_in;
   end

   assign out_valid   = outv_ff;
   assign out_sample  = outs_ff;
   assign out_channel = outc_ff;

endmodule
